// ===== src/far_pkg.sv =====
package far_pkg;

	localparam int NumLimit = 20000;
	localparam int DenLimit = 21000;

	// Width of the shared divider operands.
	localparam int DivW = 32;

	// Which source feeds the divider.
	typedef enum logic [2:0] {
		SEL_DEN  = 3'd0,
		SEL_SUM  = 3'd1,
		SEL_RED  = 3'd2,
		SEL_COMA = 3'd3,
		SEL_COMB = 3'd4,
		SEL_DAG  = 3'd5,
		SEL_COMG = 3'd6
	} div_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic     load;
		logic     gcd_init;
		logic     div_start;
		div_sel_t div_sel;
		logic     gcd_step;
		logic     take_common;
		logic     take_mul_a;
		logic     take_mul_b;
		logic     take_sum;
		logic     take_rnum;
		logic     take_rden;
		logic     take_mixed;
		logic     finish;
	} far_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic div_done;
		logic gcd_y_zero;
		logic sum_zero;
		logic mixed;
	} far_sts_t;

endpackage

// ===== src/fraction_add_reduce_top.sv =====
// Adds two fractions with signed numerators and positive denominators over
// their least common denominator and reduces the sum by the gcd of its
// magnitude and that denominator; out-of-range operands are clamped first.
// One transaction at a time: the block stalls its input from acceptance until
// the result transaction is taken. Latency is data dependent and set by the
// shared 32-bit restoring divider, one quotient bit a cycle, with one division
// per Euclid step of the two gcd loops plus three more for a zero sum or six
// otherwise.
module fraction_add_reduce_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] num_a,
	input  logic [14:0]        den_a,
	input  logic signed [15:0] num_b,
	input  logic [14:0]        den_b,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [30:0] sum_num,
	output logic [28:0]        sum_den,
	output logic [29:0]        divisor_used,
	output logic               is_zero,
	output logic               is_mixed,
	output logic [29:0]        whole_part,
	output logic [28:0]        rem_part
);

	far_pkg::far_cmd_t cmd;
	far_pkg::far_sts_t sts;

	far_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall, .cmd, .sts
	);

	far_dp u_dp (
		.clk, .arst_n, .cmd, .sts, .num_a, .den_a, .num_b, .den_b,
		.sum_num, .sum_den, .divisor_used, .is_zero, .is_mixed,
		.whole_part, .rem_part
	);

endmodule

// ===== src/far_div.sv =====
// Restoring divider, one quotient bit per cycle.
module far_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [far_pkg::DivW-1:0]    dividend,
	input  logic [far_pkg::DivW-1:0]    divisor,
	output logic                        done,
	output logic [far_pkg::DivW-1:0]    quot,
	output logic [far_pkg::DivW-1:0]    rem
);

	localparam int CntW = $clog2(far_pkg::DivW + 1);

	logic [far_pkg::DivW-1:0] q_q;
	logic [far_pkg::DivW-1:0] r_q;
	logic [far_pkg::DivW-1:0] d_q;
	logic [CntW-1:0]          cnt_q;
	logic                     busy_q;
	logic [far_pkg::DivW:0]   trial;

	// Shift in the next dividend bit and try one subtraction.
	assign trial = {r_q, q_q[far_pkg::DivW-1]} - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CntW'(far_pkg::DivW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CntW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (busy_q) begin
			if (!trial[far_pkg::DivW]) begin
				r_q <= trial[far_pkg::DivW-1:0];
				q_q <= {q_q[far_pkg::DivW-2:0], 1'b1};
			end else begin
				r_q <= {r_q[far_pkg::DivW-2:0], q_q[far_pkg::DivW-1]};
				q_q <= {q_q[far_pkg::DivW-2:0], 1'b0};
			end
		end
	end

	// Done whenever no division runs; quotient and remainder hold until the next start.
	assign done = !busy_q;
	assign quot = q_q;
	assign rem  = r_q;

endmodule

// ===== src/far_dp.sv =====
// Datapath: operand clamp, gcd registers, multiplier and result registers.
module far_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  far_pkg::far_cmd_t   cmd,
	output far_pkg::far_sts_t   sts,
	input  logic signed [15:0]  num_a,
	input  logic [14:0]         den_a,
	input  logic signed [15:0]  num_b,
	input  logic [14:0]         den_b,
	output logic signed [30:0]  sum_num,
	output logic [28:0]         sum_den,
	output logic [29:0]         divisor_used,
	output logic                is_zero,
	output logic                is_mixed,
	output logic [29:0]         whole_part,
	output logic [28:0]         rem_part
);

	logic signed [15:0] na_q, nb_q;
	logic [14:0]        da_q, db_q;
	logic [31:0]        gx_q, gy_q;
	logic [29:0]        common_q;
	logic signed [31:0] ta_q, tb_q;
	logic signed [31:0] sum_q;
	logic [31:0]        mag;
	logic [31:0]        dvd, dvs, quot, rem;
	logic               div_done;
	logic signed [30:0] rnum_q;
	logic [28:0]        rden_q;
	logic signed [15:0] na_c, nb_c;
	logic [14:0]        da_c, db_c;

	// Clamp the incoming operands into their legal ranges.
	always_comb begin
		na_c = num_a;
		if (num_a > 16'sd20000)  na_c = 16'sd20000;
		if (num_a < -16'sd20000) na_c = -16'sd20000;
		nb_c = num_b;
		if (num_b > 16'sd20000)  nb_c = 16'sd20000;
		if (num_b < -16'sd20000) nb_c = -16'sd20000;
		da_c = den_a;
		if (den_a == 15'd0)    da_c = 15'd1;
		if (den_a > 15'd21000) da_c = 15'd21000;
		db_c = den_b;
		if (den_b == 15'd0)    db_c = 15'd1;
		if (den_b > 15'd21000) db_c = 15'd21000;
	end

	assign mag = sum_q[31] ? 32'(-sum_q) : 32'(sum_q);

	// Divider operand selection.
	always_comb begin
		unique case (cmd.div_sel)
			far_pkg::SEL_DEN:  begin dvd = gx_q; dvs = gy_q; end
			far_pkg::SEL_SUM:  begin dvd = mag; dvs = gx_q; end
			far_pkg::SEL_RED:  begin dvd = 32'(rnum_q); dvs = 32'(rden_q); end
			far_pkg::SEL_COMA: begin dvd = 32'(common_q); dvs = 32'(da_q); end
			far_pkg::SEL_COMB: begin dvd = 32'(common_q); dvs = 32'(db_q); end
			far_pkg::SEL_DAG:  begin dvd = 32'(da_q); dvs = gx_q; end
			far_pkg::SEL_COMG: begin dvd = 32'(common_q); dvs = gx_q; end
			default:           begin dvd = gx_q; dvs = gy_q; end
		endcase
	end

	// Shared divider for the gcd steps and every data division.
	far_div u_div (
		.clk,
		.arst_n,
		.start(cmd.div_start),
		.dividend(dvd),
		.divisor(dvs),
		.done(div_done),
		.quot,
		.rem
	);

	assign sts.div_done   = div_done;
	assign sts.gcd_y_zero = (gy_q == 32'd0);
	assign sts.sum_zero   = (sum_q == 32'sd0);
	assign sts.mixed      = (32'(rnum_q) > 32'(rden_q)) && (rden_q != 29'd1) && !rnum_q[30];

	// Working registers, advanced by controller commands.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			na_q <= na_c;
			nb_q <= nb_c;
			da_q <= da_c;
			db_q <= db_c;
			gx_q <= 32'(da_c);
			gy_q <= 32'(db_c);
		end else if (cmd.gcd_init) begin
			gx_q <= mag;
			gy_q <= 32'(common_q);
		end else if (cmd.gcd_step) begin
			gx_q <= gy_q;
			gy_q <= rem;
		end
		if (cmd.take_common) begin
			// da / gcd is in quot; multiply by db.
			common_q <= 30'(quot[14:0]) * 30'(db_q);
		end
		if (cmd.take_mul_a) begin
			ta_q <= 32'(na_q) * $signed({16'd0, quot[15:0]});
		end
		if (cmd.take_mul_b) begin
			tb_q <= 32'(nb_q) * $signed({16'd0, quot[15:0]});
		end
		if (cmd.take_sum) begin
			sum_q <= ta_q + tb_q;
		end
		if (cmd.take_rnum) begin
			rnum_q <= sum_q[31] ? -31'(quot) : 31'(quot);
		end
		if (cmd.take_rden) begin
			rden_q <= 29'(quot);
		end
	end

	// Output registers, loaded when a result is finished.
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			if (sum_q == 32'sd0) begin
				sum_num      <= '0;
				sum_den      <= 29'd1;
				divisor_used <= 30'd1;
				is_zero      <= 1'b1;
				is_mixed     <= 1'b0;
				whole_part   <= '0;
				rem_part     <= '0;
			end else begin
				sum_num      <= rnum_q;
				sum_den      <= rden_q;
				divisor_used <= 30'(gx_q);
				is_zero      <= 1'b0;
				is_mixed     <= cmd.take_mixed;
				whole_part   <= cmd.take_mixed ? 30'(quot) : 30'd0;
				rem_part     <= cmd.take_mixed ? 29'(rem) : 29'd0;
			end
		end
	end

endmodule

// ===== src/far_ctrl.sv =====
// Controller: sequences the gcd loops, divisions and the output handshake.
module far_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	output far_pkg::far_cmd_t cmd,
	input  far_pkg::far_sts_t sts
);

	typedef enum logic [13:0] {
		S_IDLE  = 14'b00000000000001,
		S_G1    = 14'b00000000000010,
		S_G1W   = 14'b00000000000100,
		S_CMW   = 14'b00000000001000,
		S_MAW   = 14'b00000000010000,
		S_MBW   = 14'b00000000100000,
		S_SUM   = 14'b00000001000000,
		S_G2    = 14'b00000010000000,
		S_G2W   = 14'b00000100000000,
		S_RNW   = 14'b00001000000000,
		S_RDW   = 14'b00010000000000,
		S_MXW   = 14'b00100000000000,
		S_FIN   = 14'b01000000000000,
		S_OUT   = 14'b10000000000000
	} state_t;

	state_t state_q, state_d;
	logic   pend_q, pend_d;
	logic   mixed_q, mixed_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pend_q  <= 1'b0;
			mixed_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_q  <= pend_d;
			mixed_q <= mixed_d;
		end
	end

	// Next state and commands. pend marks the first cycle after a division
	// was started or after operands were registered, and lasts one cycle.
	always_comb begin
		state_d = state_q;
		pend_d  = 1'b0;
		mixed_d = mixed_q;
		cmd     = '0;
		cmd.div_sel = far_pkg::SEL_DEN;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_G1;
				end
			end
			S_G1: begin
				cmd.div_start = 1'b1;
				pend_d        = 1'b1;
				if (sts.gcd_y_zero) begin
					// gcd of denominators is in gx; divide da by it.
					cmd.div_sel = far_pkg::SEL_DAG;
					state_d     = S_CMW;
				end else begin
					cmd.div_sel = far_pkg::SEL_DEN;
					state_d     = S_G1W;
				end
			end
			S_G1W: begin
				if (!pend_q && sts.div_done) begin
					cmd.gcd_step = 1'b1;
					state_d      = S_G1;
				end
			end
			S_CMW: begin
				if (!pend_q && sts.div_done) begin
					cmd.take_common = 1'b1;
					state_d         = S_MAW;
					pend_d          = 1'b1;
				end
			end
			S_MAW: begin
				if (pend_q) begin
					// The common denominator is registered now.
					cmd.div_sel   = far_pkg::SEL_COMA;
					cmd.div_start = 1'b1;
				end else if (sts.div_done) begin
					cmd.take_mul_a = 1'b1;
					cmd.div_sel    = far_pkg::SEL_COMB;
					cmd.div_start  = 1'b1;
					pend_d         = 1'b1;
					state_d        = S_MBW;
				end
			end
			S_MBW: begin
				if (!pend_q && sts.div_done) begin
					cmd.take_mul_b = 1'b1;
					state_d        = S_SUM;
				end
			end
			S_SUM: begin
				cmd.take_sum = 1'b1;
				state_d      = S_G2;
				pend_d       = 1'b1;
			end
			S_G2: begin
				if (pend_q) begin
					if (sts.sum_zero) begin
						state_d = S_FIN;
					end else begin
						cmd.gcd_init = 1'b1;
					end
				end else if (sts.gcd_y_zero) begin
					// gcd is in gx: reduce the numerator magnitude.
					cmd.div_sel   = far_pkg::SEL_SUM;
					cmd.div_start = 1'b1;
					pend_d        = 1'b1;
					state_d       = S_RNW;
				end else begin
					cmd.div_start = 1'b1;
					pend_d        = 1'b1;
					state_d       = S_G2W;
				end
			end
			S_G2W: begin
				if (!pend_q && sts.div_done) begin
					cmd.gcd_step = 1'b1;
					state_d      = S_G2;
				end
			end
			S_RNW: begin
				if (!pend_q && sts.div_done) begin
					cmd.take_rnum = 1'b1;
					state_d       = S_RDW;
					pend_d        = 1'b1;
				end
			end
			S_RDW: begin
				if (pend_q) begin
					// Common denominator over the gcd still held in gx.
					cmd.div_sel   = far_pkg::SEL_COMG;
					cmd.div_start = 1'b1;
				end else if (sts.div_done) begin
					cmd.take_rden = 1'b1;
					state_d       = S_MXW;
					pend_d        = 1'b1;
				end
			end
			S_MXW: begin
				if (pend_q) begin
					mixed_d       = sts.mixed;
					cmd.div_sel   = far_pkg::SEL_RED;
					cmd.div_start = 1'b1;
				end else if (sts.div_done) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				cmd.div_sel    = far_pkg::SEL_RED;
				cmd.finish     = 1'b1;
				cmd.take_mixed = mixed_q && !sts.sum_zero;
				state_d        = S_OUT;
			end
			S_OUT: begin
				if (!out_stall) begin
					mixed_d = 1'b0;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);

endmodule

// ===== src/far_checker.sv =====
// Port-level checks on the top level.
module far_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [28:0] sum_den,
	input logic        is_zero,
	input logic        is_mixed
);

	// One transaction at a time: no input is taken while a result waits.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input taken while result pending");

	// A zero sum is never mixed and has denominator one.
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && is_zero) |-> (!is_mixed && sum_den == 29'd1))
		else $error("zero result malformed");

	// The denominator of a result is never zero.
	a_den: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (sum_den != 29'd0)) else $error("zero denominator");

	// A stalled result stays valid.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid) else $error("result dropped");

endmodule

bind fraction_add_reduce_top far_checker u_far_checker (
	.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall,
	.sum_den, .is_zero, .is_mixed
);

// ===== dv/tb.sv =====
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IdlePct = 37;
	localparam int WatchdogLimit = 40000;
	localparam int DrainCycles = 50;
	localparam int HoldCycles = 3000;

	// One expected reduced sum, at the widths of the result ports.
	typedef struct packed {
		logic signed [30:0] num;
		logic [28:0]        den;
		logic [29:0]        divisor;
		logic               zero;
		logic               mixed;
		logic [29:0]        whole;
		logic [28:0]        rem;
	} reduced_sum_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [15:0] num_a = '0;
	logic [14:0] den_a = 15'd1;
	logic signed [15:0] num_b = '0;
	logic [14:0] den_b = 15'd1;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [30:0] sum_num;
	logic [28:0] sum_den;
	logic [29:0] divisor_used;
	logic is_zero;
	logic is_mixed;
	logic [29:0] whole_part;
	logic [28:0] rem_part;

	reduced_sum_t expected_sums[$];
	int errors = 0;
	int sums_checked = 0;
	int zero_sums = 0;
	int mixed_sums = 0;
	int pairs_sent = 0;
	bit sender_idles = 1'b1;
	bit receiver_idles = 1'b1;
	int hold_requests = 0;
	int holds_served = 0;
	int receiver_hold = 0;
	int quiet_cycles = 0;

	fraction_add_reduce_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.num_a(num_a),
		.den_a(den_a),
		.num_b(num_b),
		.den_b(den_b),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sum_num(sum_num),
		.sum_den(sum_den),
		.divisor_used(divisor_used),
		.is_zero(is_zero),
		.is_mixed(is_mixed),
		.whole_part(whole_part),
		.rem_part(rem_part)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Numerators saturate at the magnitude limit.
	function automatic longint sat_num(logic signed [15:0] raw);
		longint v;
		v = raw;
		if (v > far_pkg::NumLimit) v = far_pkg::NumLimit;
		if (v < -far_pkg::NumLimit) v = -far_pkg::NumLimit;
		return v;
	endfunction

	// Denominators of zero count as one and saturate at the upper limit.
	function automatic longint sat_den(logic [14:0] raw);
		longint v;
		v = raw;
		if (v < 1) v = 1;
		if (v > far_pkg::DenLimit) v = far_pkg::DenLimit;
		return v;
	endfunction

	function automatic longint euclid_gcd(longint x, longint y);
		longint t;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		return x;
	endfunction

	// Adds the two fractions over their lcm and reduces the result.
	function automatic reduced_sum_t add_and_reduce(logic signed [15:0] ra, logic [14:0] rda,
			logic signed [15:0] rb, logic [14:0] rdb);
		longint na, da, nb, db, common, total, mag, g, rnum, rden;
		reduced_sum_t r;
		na = sat_num(ra);
		da = sat_den(rda);
		nb = sat_num(rb);
		db = sat_den(rdb);
		common = (da / euclid_gcd(da, db)) * db;
		total = na * (common / da) + nb * (common / db);
		r = '0;
		r.den = 29'd1;
		r.divisor = 30'd1;
		if (total == 0) begin
			r.zero = 1'b1;
		end else begin
			mag = total < 0 ? -total : total;
			g = euclid_gcd(mag, common);
			rnum = total / g;
			rden = common / g;
			r.num = 31'(rnum);
			r.den = 29'(rden);
			r.divisor = 30'(g);
			if (rnum > rden && rden != 1) begin
				r.mixed = 1'b1;
				r.whole = 30'(rnum / rden);
				r.rem = 29'(rnum % rden);
			end
		end
		return r;
	endfunction

	// Offers one fraction pair and records its expected sum once accepted.
	task automatic send_pair(logic signed [15:0] na, logic [14:0] da,
			logic signed [15:0] nb, logic [14:0] db);
		int gap;
		if (sender_idles && $urandom_range(99) < IdlePct) begin
			gap = $urandom_range(6, 1);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		num_a <= na;
		den_a <= da;
		num_b <= nb;
		den_b <= db;
		do @(posedge clk); while (in_stall);
		expected_sums.push_back(add_and_reduce(na, da, nb, db));
		pairs_sent++;
	endtask

	task automatic end_offer();
		in_valid <= 1'b0;
	endtask

	task automatic wait_all_sums();
		while (expected_sums.size() != 0) @(posedge clk);
	endtask

	function automatic logic [14:0] pick_den();
		unique case ($urandom_range(9))
			0: return 15'($urandom_range(32767));
			1: return 15'($urandom_range(21000, 20000));
			2, 3: return 15'($urandom_range(21000, 1));
			default: return 15'($urandom_range(60, 1));
		endcase
	endfunction

	function automatic logic signed [15:0] pick_num();
		unique case ($urandom_range(9))
			0: return 16'($urandom_range(65535));
			1: return $urandom_range(1) ? 16'sd20000 : -16'sd20000;
			2, 3: return $signed(16'($urandom_range(40000))) - 16'sd20000;
			default: return $signed(16'($urandom_range(200))) - 16'sd100;
		endcase
	endfunction

	// Field limits and the saturation of out-of-range inputs.
	task automatic test_extremes();
		send_pair(16'sd20000, 15'd1, 16'sd20000, 15'd1);
		send_pair(-16'sd20000, 15'd1, -16'sd20000, 15'd1);
		send_pair(16'sd20000, 15'd21000, 16'sd19999, 15'd20999);
		send_pair(-16'sd20000, 15'd20999, 16'sd1, 15'd21000);
		send_pair(16'sh7FFF, 15'd0, 16'sh8000, 15'h7FFF);
		send_pair(16'shFFFF, 15'h7FFF, 16'sh7FFF, 15'd0);
		send_pair(16'sh5555, 15'h2AAA, 16'shAAAA, 15'h5555);
		send_pair(16'sd0, 15'd0, 16'sd0, 15'd21000);
		end_offer();
	endtask

	// Equal, dividing and coprime denominators, zero, negative and mixed sums.
	task automatic test_special_cases();
		send_pair(16'sd1, 15'd2, -16'sd1, 15'd2);
		send_pair(16'sd3, 15'd4, -16'sd6, 15'd8);
		send_pair(16'sd3, 15'd7, 16'sd2, 15'd7);
		send_pair(16'sd1, 15'd3, 16'sd5, 15'd12);
		send_pair(16'sd2, 15'd9, 16'sd3, 15'd10);
		send_pair(-16'sd7, 15'd3, 16'sd1, 15'd5);
		send_pair(16'sd7, 15'd3, 16'sd11, 15'd5);
		send_pair(16'sd5, 15'd3, 16'sd1, 15'd3);
		send_pair(16'sd9, 15'd4, 16'sd3, 15'd4);
		send_pair(16'sd1, 15'd6, 16'sd1, 15'd6);
		send_pair(16'sd3, 15'd2, 16'sd0, 15'd5);
		end_offer();
	endtask

	task automatic test_random(int count);
		repeat (count) send_pair(pick_num(), pick_den(), pick_num(), pick_den());
		end_offer();
	endtask

	// The receiver holds off while the sender keeps offering, then the sender pauses.
	task automatic test_backpressure();
		hold_requests++;
		test_random(6);
		wait_all_sums();
		test_random(20);
		wait_all_sums();
	endtask

	// Stalls downstream, counted here so the hold is independent of the sender.
	always @(posedge clk) begin
		if (receiver_hold > 0) begin
			out_stall <= 1'b1;
			receiver_hold <= receiver_hold - 1;
		end else if (hold_requests != holds_served) begin
			out_stall <= 1'b1;
			receiver_hold <= HoldCycles - 1;
			holds_served <= holds_served + 1;
		end else begin
			out_stall <= receiver_idles && ($urandom_range(99) < IdlePct);
		end
	end

	task automatic check_field(string name, longint exp, longint act);
		if (exp != act) begin
			$error("%s mismatch: expected %0d, got %0d", name, exp, act);
			errors++;
		end
	endtask

	// Compares each result transaction against the oldest expected sum.
	always @(posedge clk) begin
		reduced_sum_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_sums.size() == 0) begin
				$error("result transaction with no expected sum pending");
				errors++;
			end else begin
				e = expected_sums.pop_front();
				check_field("sum_num", e.num, sum_num);
				check_field("sum_den", e.den, sum_den);
				check_field("divisor_used", e.divisor, divisor_used);
				check_field("is_zero", e.zero, is_zero);
				check_field("is_mixed", e.mixed, is_mixed);
				check_field("whole_part", e.whole, whole_part);
				check_field("rem_part", e.rem, rem_part);
				sums_checked++;
				zero_sums += e.zero;
				mixed_sums += e.mixed;
			end
		end
	end

	// Ends the run when neither side moves for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WatchdogLimit) begin
			$display("watchdog: no transaction for %0d cycles", WatchdogLimit);
			$display("DONE: errors detected");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_special_cases();
		test_backpressure();
		test_random(300);
		sender_idles = 1'b0;
		receiver_idles = 1'b0;
		test_random(150);
		sender_idles = 1'b1;
		receiver_idles = 1'b1;
		test_random(300);
		wait_all_sums();
		repeat (DrainCycles) @(posedge clk);
		$display("Covered %0d fraction pairs (%0d results checked, %0d zero, %0d mixed),",
			pairs_sent, sums_checked, zero_sums, mixed_sums);
		$display("with saturated inputs, random idles, a long output hold and a sender pause.");
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

`default_nettype wire
